### design/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg: shared types and constants of the rectangle raster painter
// Operation codes, result codes, register indexes and the control and status
// groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Field widths fixed by the interface
  localparam int FIELD_W = 20;   // Q12.8 coordinate fields
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 9;    // widest configuration register
  localparam int DIM_W   = 11;   // holds a clamped canvas size up to 1024

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  // Shape letters
  localparam logic [CHAR_W-1:0] LETTER_OUTLINE = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] LETTER_FILLED  = 8'h52;  // 'R'

  // Reset values of the registers
  localparam logic [CFG_W-1:0]  RESET_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0]  RESET_HEIGHT = 9'd256;
  localparam logic [CHAR_W-1:0] RESET_BG     = 8'd32;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_SHAPE = 2'd1,
    STAT_OUTSIDE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_READ,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture an accepted item
    logic step;   // advance the pixel sweep by one pixel
    logic rd;     // read one canvas pixel
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  bad_shape;
    logic  outside;
    logic  last;  // sweep sits on the last pixel of the canvas
  } dp_stat_t;

endpackage

### design/rectangle_raster_painter_top.sv
// ----------------------------------------------------------------------------
// rectangle_raster_painter_top: character canvas with rectangle drawing
// Clears the canvas, draws filled or outline rectangles given in signed
// fixed point, and reads back single pixels.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   item     | start, busy            | mode, shape_letter, left_edge, top_edge,
//            |                        | rect_width, rect_height, paint_char,
//            |                        | read_column, read_row
//   result   | done (one-cycle pulse) | status, pixel_char
//   config   | cfg_write              | cfg_index, cfg_data
//
// An item is taken when start is high and busy is low. Clear and a good draw
// run the pixel sweep over the canvas size in use, which writes one pixel per
// cycle through the single memory write port. Read adds one registered memory
// read; a bad shape, a read outside the canvas and the no-op mode go straight
// to the result without a sweep or a read.
// Reset sets the registers to 256, 256 and 32; canvas contents are undefined
// until cleared or drawn. done is high for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module rectangle_raster_painter_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [rrp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode,
  input  logic [7:0]                shape_letter,
  input  logic signed [19:0]        left_edge,
  input  logic signed [19:0]        top_edge,
  input  logic signed [19:0]        rect_width,
  input  logic signed [19:0]        rect_height,
  input  logic [7:0]                paint_char,
  input  logic [7:0]                read_column,
  input  logic [7:0]                read_row,
  output logic                      done,
  output logic [1:0]                status,
  output logic [7:0]                pixel_char
);
  import rrp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rrp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Registers, canvas and sweep
  rrp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .shape_letter (shape_letter),
    .left_edge    (left_edge),
    .top_edge     (top_edge),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .paint_char   (paint_char),
    .read_column  (read_column),
    .read_row     (read_row),
    .status       (status),
    .pixel_char   (pixel_char)
  );

  // A result always ends the transfer and frees the block
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  // Only a successful read returns a nonzero character
  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != STAT_OK || stat.mode != MODE_READ) |-> pixel_char == '0)
    else $error("character returned outside a good read");

  // An accepted item makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

endmodule

### design/rrp_ctrl.sv
// ----------------------------------------------------------------------------
// rrp_ctrl: sequencer of the rectangle raster painter
// Accepts an item, decides its path from the datapath flags, runs the pixel
// sweep or the single read, and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module rrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output rrp_pkg::dp_cmd_t  cmd,
  input  rrp_pkg::dp_stat_t stat
);
  import rrp_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.mode)
          MODE_CLEAR: state_next = ST_SWEEP;
          MODE_DRAW:  state_next = stat.bad_shape ? ST_RESP : ST_SWEEP;
          MODE_READ:  state_next = stat.outside ? ST_RESP : ST_READ;
          default:    state_next = ST_RESP;
        endcase
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = ST_RESP;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A sweep only runs for clear or for a good draw
  a_sweep_path: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (stat.mode == MODE_CLEAR) || (stat.mode == MODE_DRAW && !stat.bad_shape))
    else $error("pixel sweep on an item that paints nothing");

  // A read is only issued for an in-range pixel
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (stat.mode == MODE_READ) && !stat.outside)
    else $error("canvas read outside the canvas");

  // Every accepted item passes through decode before its result
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !done)
    else $error("result strobed right after accept");

endmodule

### design/rrp_datapath.sv
// ----------------------------------------------------------------------------
// rrp_datapath: registers, canvas memory and pixel sweep of the painter
// Holds the configuration, the captured item, the sweep counters and the
// incremental edge distances that decide which pixels a rectangle covers.
// ----------------------------------------------------------------------------
module rrp_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [rrp_pkg::CFG_W-1:0]    cfg_data,
  input  rrp_pkg::dp_cmd_t             cmd,
  output rrp_pkg::dp_stat_t            stat,
  input  logic [1:0]                   mode,
  input  logic [7:0]                   shape_letter,
  input  logic signed [19:0]           left_edge,
  input  logic signed [19:0]           top_edge,
  input  logic signed [19:0]           rect_width,
  input  logic signed [19:0]           rect_height,
  input  logic [7:0]                   paint_char,
  input  logic [7:0]                   read_column,
  input  logic [7:0]                   read_row,
  output logic [1:0]                   status,
  output logic [7:0]                   pixel_char
);
  import rrp_pkg::*;

  localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = ((XW > YW) ? XW : YW) + FRAC_BITS + 2;
  localparam int CW    = (PW > FIELD_W + 2) ? PW : FIELD_W + 2;
  localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
  localparam logic [DIM_W-1:0]     MAXW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]     MAXH = DIM_W'(MAX_HEIGHT);

  // Configuration registers
  logic [CFG_W-1:0]  canvas_width;
  logic [CFG_W-1:0]  canvas_height;
  logic [CHAR_W-1:0] background_char;

  // Captured item
  mode_t             mode_q;
  status_t           status_q;
  logic              bad_q;
  logic              outside_q;
  logic              filled_q;
  logic [CHAR_W-1:0] paint_q;
  logic [XW-1:0]     col_q;
  logic [YW-1:0]     row_q;
  logic signed [CW-1:0] neg_left;
  logic signed [CW-1:0] right_pos;

  // Sweep state: pixel position and distances to the left, right, top and bottom edges
  logic [XW-1:0]        x;
  logic [YW-1:0]        y;
  logic signed [CW-1:0] dx_l, dx_r, dy_t, dy_b;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] col_ext, row_ext;
  logic             bad_in, outside_in;
  status_t          status_in;
  logic             last_col, last_row;
  logic             in_x, in_y, border, hit, mem_we;
  logic [AW-1:0]    rd_addr;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= RESET_WIDTH;
      canvas_height   <= RESET_HEIGHT;
      background_char <= RESET_BG;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WIDTH:  canvas_width    <= cfg_data;
        CFG_HEIGHT: canvas_height   <= cfg_data;
        CFG_BG:     background_char <= cfg_data[CHAR_W-1:0];
        default:    ;
      endcase
    end
  end

  // Canvas size in use: zero acts as one, large values clamp to the maximum
  always_comb begin
    if (canvas_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(canvas_width) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = DIM_W'(canvas_width);
    end
    if (canvas_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(canvas_height) > MAXH) begin
      h_eff = MAXH;
    end else begin
      h_eff = DIM_W'(canvas_height);
    end
  end

  // Item checks taken at accept
  assign col_ext    = DIM_W'(read_column);
  assign row_ext    = DIM_W'(read_row);
  assign bad_in     = (rect_width <= 0) || (rect_height <= 0) ||
                      ((shape_letter != LETTER_OUTLINE) && (shape_letter != LETTER_FILLED));
  assign outside_in = (col_ext >= w_eff) || (row_ext >= h_eff);

  always_comb begin
    status_in = STAT_OK;
    if (mode_t'(mode) == MODE_DRAW && bad_in) begin
      status_in = STAT_BAD_SHAPE;
    end else if (mode_t'(mode) == MODE_READ && outside_in) begin
      status_in = STAT_OUTSIDE;
    end
  end

  // Capture of an accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q    <= mode_t'(mode);
      status_q  <= status_in;
      bad_q     <= bad_in;
      outside_q <= outside_in;
      filled_q  <= (shape_letter == LETTER_FILLED);
      paint_q   <= paint_char;
      col_q     <= col_ext[XW-1:0];
      row_q     <= row_ext[YW-1:0];
      neg_left  <= -CW'(left_edge);
      right_pos <= CW'(left_edge) + CW'(rect_width);
    end
  end

  // Coverage of the current pixel from the edge distances
  assign in_x   = !dx_l[CW-1] && !dx_r[CW-1];
  assign in_y   = !dy_t[CW-1] && !dy_b[CW-1];
  assign border = (dx_l < ONE) || (dx_r < ONE) || (dy_t < ONE) || (dy_b < ONE);
  assign hit    = in_x && in_y && (filled_q || border);

  assign last_col = (DIM_W'(x) == w_eff - DIM_W'(1));
  assign last_row = (DIM_W'(y) == h_eff - DIM_W'(1));

  // Sweep counters and incremental distances, one pixel per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= '0;
      y    <= '0;
      dx_l <= -CW'(left_edge);
      dx_r <= CW'(left_edge) + CW'(rect_width);
      dy_t <= -CW'(top_edge);
      dy_b <= CW'(top_edge) + CW'(rect_height);
    end else if (cmd.step) begin
      if (last_col) begin
        x    <= '0;
        y    <= y + YW'(1);
        dx_l <= neg_left;
        dx_r <= right_pos;
        dy_t <= dy_t + ONE;
        dy_b <= dy_b - ONE;
      end else begin
        x    <= x + XW'(1);
        dx_l <= dx_l + ONE;
        dx_r <= dx_r - ONE;
      end
    end
  end

  // Canvas memory: one write port for the sweep, one registered read
  assign mem_we  = cmd.step && ((mode_q == MODE_CLEAR) || hit);
  assign rd_addr = {row_q, col_q};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{y, x}] <= (mode_q == MODE_CLEAR) ? background_char : paint_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end else if (cmd.load) begin
      rd_data <= '0;
    end
  end

  // Status to the controller and result fields
  assign stat.mode      = mode_q;
  assign stat.bad_shape = bad_q;
  assign stat.outside   = outside_q;
  assign stat.last      = last_col && last_row;

  assign status     = status_q;
  assign pixel_char = rd_data;

endmodule
